// ===== rtl/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared constants and the token type that travels along the ARP cache cells.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

	localparam int unsigned ENTRIES = 16;

	localparam logic [15:0] MIN_FRAME_BYTES = 16'd42;
	localparam logic [15:0] OPCODE_REPLY    = 16'd2;

	localparam logic [1:0] DROP_NONE      = 2'd0;
	localparam logic [1:0] DROP_SHORT     = 2'd1;
	localparam logic [1:0] DROP_NOT_REPLY = 2'd2;
	localparam logic [1:0] DROP_FULL      = 2'd3;

	localparam logic KIND_LOOKUP = 1'b0;
	localparam logic KIND_INSERT = 1'b1;

	typedef struct packed {
		logic        vld;
		logic        kind;
		logic        done;
		logic [1:0]  drop;
		logic [31:0] ip;
		logic [47:0] mac;
	} tok_t;

endpackage

`default_nettype wire

// ===== rtl/arpc_in_if.sv =====
// ----------------------------------------------------------------------------
// arpc_in_if
// Request channel of the ARP cache: resolve lookups and received ARP packets.
// ----------------------------------------------------------------------------
`default_nettype none

interface arpc_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [31:0] lookup_ip;
	logic [15:0] frame_length;
	logic [15:0] arp_opcode;
	logic [31:0] peer_ip;
	logic [47:0] peer_mac;

	modport source (
		output valid, mode, lookup_ip, frame_length, arp_opcode, peer_ip, peer_mac,
		input  ready
	);
	modport sink (
		input  valid, mode, lookup_ip, frame_length, arp_opcode, peer_ip, peer_mac,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/arpc_out_if.sv =====
// ----------------------------------------------------------------------------
// arpc_out_if
// Result channel of the ARP cache: one beat per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface arpc_out_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [47:0] resolved_mac;
	logic        request_needed;
	logic        inserted;
	logic [1:0]  drop_reason;

	modport source (
		output valid, hit, resolved_mac, request_needed, inserted, drop_reason,
		input  ready
	);
	modport sink (
		input  valid, hit, resolved_mac, request_needed, inserted, drop_reason,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/arpc_cell.sv =====
// ----------------------------------------------------------------------------
// arpc_cell
// One table entry. Match or claim the entry as the token passes, then hand
// the token to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire arpc_pkg::tok_t tok_in,
	output arpc_pkg::tok_t      tok_out
);

	logic           valid_q;
	logic [31:0]    ip_q;
	logic [47:0]    mac_q;
	arpc_pkg::tok_t tok_q;
	arpc_pkg::tok_t tok_nxt;
	logic           wr;

	always_comb begin
		tok_nxt = tok_in;
		wr      = 1'b0;
		if (tok_in.vld && !tok_in.done) begin
			case (tok_in.kind)
				arpc_pkg::KIND_LOOKUP: begin
					if (valid_q && (ip_q == tok_in.ip)) begin
						tok_nxt.done = 1'b1;
						tok_nxt.mac  = mac_q;
					end
				end
				arpc_pkg::KIND_INSERT: begin
					if (!valid_q) begin
						tok_nxt.done = 1'b1;
						wr           = 1'b1;
					end
				end
				default: begin
					tok_nxt = tok_in;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (wr) begin
				valid_q <= 1'b1;
			end
		end
	end

	// entry payload: written once when claimed
	always_ff @(posedge clk) begin
		if (wr) begin
			ip_q  <= tok_in.ip;
			mac_q <= tok_in.mac;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

// ===== rtl/arp_cache_lookup_insert_top.sv =====
// ----------------------------------------------------------------------------
// arp_cache_lookup_insert_top
// IPv4-to-MAC cache built as a row of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   item   : request beats. mode 0 resolves lookup_ip; mode 1 offers a
//            received ARP packet (frame_length, arp_opcode, peer_ip/mac).
//   result : one beat per request: hit/resolved_mac/request_needed for a
//            lookup, inserted/drop_reason for a received packet.
//   A request enters the first cell as a token and moves one cell per
//   cycle through all ENTRIES cells (16), then into a holding register and
//   the output register, which drives the result beat. One request is in
//   flight at a time: the next item is taken only once the result has left
//   the holding register for the output register.
//   The walk along the cell row makes up most of the delay from item to result.
//   Reset clears every entry's valid flag at once; no clearing pass.
//   When the receiver stalls the result holds in the output register; the
//   next item is still taken, and its result waits in the holding register
//   until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cache_lookup_insert_top (
	input  wire logic clk,
	input  wire logic arst_n,
	arpc_in_if.sink   item,
	arpc_out_if.source result
);

	arpc_pkg::tok_t tok_chain [0:arpc_pkg::ENTRIES];
	arpc_pkg::tok_t tok_head;
	arpc_pkg::tok_t pend_q;
	logic           busy_q;
	logic           accept;
	logic           is_short;
	logic           not_reply;
	logic           pend_move;

	logic           out_vld_q;
	logic           hit_q;
	logic [47:0]    mac_q;
	logic           req_q;
	logic           ins_q;
	logic [1:0]     drop_q;

	assign item.ready = !busy_q;
	assign accept     = item.valid && !busy_q;

	// classify a received packet up front; a dropped one needs no cell
	assign is_short  = item.frame_length < arpc_pkg::MIN_FRAME_BYTES;
	assign not_reply = item.arp_opcode != arpc_pkg::OPCODE_REPLY;

	always_comb begin
		tok_head.vld  = accept;
		tok_head.kind = item.mode ? arpc_pkg::KIND_INSERT : arpc_pkg::KIND_LOOKUP;
		tok_head.done = item.mode && (is_short || not_reply);
		if (!item.mode) begin
			tok_head.drop = arpc_pkg::DROP_NONE;
		end else if (is_short) begin
			tok_head.drop = arpc_pkg::DROP_SHORT;
		end else if (not_reply) begin
			tok_head.drop = arpc_pkg::DROP_NOT_REPLY;
		end else begin
			tok_head.drop = arpc_pkg::DROP_NONE;
		end
		tok_head.ip  = item.mode ? item.peer_ip : item.lookup_ip;
		tok_head.mac = item.mode ? item.peer_mac : 48'd0;
	end

	assign tok_chain[0] = tok_head;

	// row of entry cells, cell 0 has priority
	for (genvar g = 0; g < arpc_pkg::ENTRIES; g++) begin : g_cell
		arpc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok_chain[g]),
			.tok_out (tok_chain[g+1])
		);
	end

	// advance the holding register into the output register when it frees
	assign pend_move = pend_q.vld && (!out_vld_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			pend_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (pend_move) begin
				busy_q <= 1'b0;
			end
			if (tok_chain[arpc_pkg::ENTRIES].vld) begin
				pend_q <= tok_chain[arpc_pkg::ENTRIES];
			end else if (pend_move) begin
				pend_q.vld <= 1'b0;
			end
			if (pend_move) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// result fields from the finished token
	always_ff @(posedge clk) begin
		if (pend_move) begin
			case (pend_q.kind)
				arpc_pkg::KIND_LOOKUP: begin
					hit_q  <= pend_q.done;
					mac_q  <= pend_q.done ? pend_q.mac : 48'd0;
					req_q  <= !pend_q.done;
					ins_q  <= 1'b0;
					drop_q <= arpc_pkg::DROP_NONE;
				end
				arpc_pkg::KIND_INSERT: begin
					hit_q <= 1'b0;
					mac_q <= 48'd0;
					req_q <= 1'b0;
					if (pend_q.drop != arpc_pkg::DROP_NONE) begin
						ins_q  <= 1'b0;
						drop_q <= pend_q.drop;
					end else begin
						ins_q  <= pend_q.done;
						drop_q <= pend_q.done ? arpc_pkg::DROP_NONE : arpc_pkg::DROP_FULL;
					end
				end
				default: begin
					hit_q  <= 1'b0;
					mac_q  <= 48'd0;
					req_q  <= 1'b0;
					ins_q  <= 1'b0;
					drop_q <= arpc_pkg::DROP_NONE;
				end
			endcase
		end
	end

	assign result.valid          = out_vld_q;
	assign result.hit            = hit_q;
	assign result.resolved_mac   = mac_q;
	assign result.request_needed = req_q;
	assign result.inserted       = ins_q;
	assign result.drop_reason    = drop_q;

endmodule

`default_nettype wire
